### design/gbcm_pkg.sv
// Shared types and constants for the GOST 28147-89 cipher engine.
package gbcm_pkg;

	localparam int unsigned KEY_WORDS = 8;
	localparam int unsigned SBOX_ROWS = 8;

	localparam logic [31:0] GAMMA_STEP_LOW  = 32'h0101_0101;
	localparam logic [31:0] GAMMA_STEP_HIGH = 32'h0101_0104;
	localparam int unsigned ROTATE_BITS = 11;

	typedef logic [KEY_WORDS-1:0][31:0] key_words_t;
	typedef logic [SBOX_ROWS-1:0][63:0] sbox_t;

	typedef enum logic [1:0] {
		OP_SYNC = 2'd0,
		OP_DATA = 2'd1,
		OP_ROW  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		MODE_ECB_ENC = 3'd0,
		MODE_ECB_DEC = 3'd1,
		MODE_CTR     = 3'd2,
		MODE_CFB_ENC = 3'd3,
		MODE_CFB_DEC = 3'd4,
		MODE_MAC     = 3'd5,
		MODE_RSVD6   = 3'd6,
		MODE_RSVD7   = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		RUN_ENC = 2'd0,
		RUN_DEC = 2'd1,
		RUN_MAC = 2'd2
	} run_kind_t;

	typedef enum logic [2:0] {
		REG_KEY01 = 3'd0,
		REG_KEY23 = 3'd1,
		REG_KEY45 = 3'd2,
		REG_KEY67 = 3'd3,
		REG_MODE  = 3'd4
	} reg_idx_t;

	// Control into the round sequencer.
	typedef struct packed {
		logic      start;
		run_kind_t kind;
	} core_ctl_t;

endpackage

### design/gost_block_cipher_modes.sv
// Top level of the GOST 28147-89 cipher engine with its six block modes.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one item per transfer: op,
//   payload, row_index, byte_count, last. A sync load or a substitution row
//   load completes in the transfer cycle and gives no result. A data block
//   gives exactly one result on the output channel (out_valid / out_ready).
//   Rounds: a full-cipher block takes 32 rounds on one shared round unit,
//   one round per cycle, plus a handoff between states; a MAC block
//   takes 16 rounds; the first counter block of a message takes 64 rounds
//   (the sync value is encrypted once before the counter starts). Short ECB
//   blocks and undefined modes skip the rounds and go straight to holding.
//   A new block is taken only once the last has left its holding register, as in_ready is
//   high only while the sequencer is idle; chaining keeps blocks apart.
//   The result register decouples the sides: a held result waits while the
//   next block is taken and ciphered; a finished block then waits in its
//   holding register until the receiver frees the output.
//   Reset clears keys, mode, chaining value, and sets start of message.
//   Substitution rows hold nothing useful until written. Keys and mode are
//   written through the APB port at byte address 8 * index.
module gost_block_cipher_modes (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [63:0] payload,
	input  logic [2:0]  row_index,
	input  logic [3:0]  byte_count,
	input  logic        last,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] data_out,
	output logic [31:0] mac_value,
	output logic [3:0]  valid_bytes,
	output logic        final_block,
	output logic        length_error
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN1,
		ST_RUN2,
		ST_HOLD
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [3:0][63:0]        key_q;
	gbcm_pkg::mode_t         mode_cfg_q;
	gbcm_pkg::key_words_t    keys;
	gbcm_pkg::reg_idx_t      reg_idx;
	logic                    cfg_wr;

	// Block state.
	gbcm_pkg::sbox_t         sbox_q;
	logic [63:0]             cv_q;
	logic                    msg_start_q;

	// Current block.
	logic [63:0]             blk_q;
	logic [63:0]             mask_q;
	logic [3:0]              cnt_q;
	logic                    last_q;
	gbcm_pkg::mode_t         mode_q;

	// Holding and output registers.
	logic [63:0]             hold_data_q;
	logic [31:0]             hold_mac_q;
	logic                    hold_err_q;
	logic                    out_valid_q;
	logic [63:0]             data_out_q;
	logic [31:0]             mac_out_q;
	logic [3:0]              vb_out_q;
	logic                    fb_out_q;
	logic                    err_out_q;

	// Round sequencer hookup.
	gbcm_pkg::core_ctl_t     core_ctl;
	logic [63:0]             core_din;
	logic                    core_done;
	logic [63:0]             core_dout;

	logic                    in_xfer;
	logic                    data_xfer;
	gbcm_pkg::op_t           op_in;
	gbcm_pkg::mode_t         mode_cur;
	logic [3:0]              cnt_sat;
	logic [63:0]             mask_in;
	logic [63:0]             blk_in;
	logic                    ecb_full;
	logic [63:0]             adv_in;
	logic [63:0]             adv_out;
	logic [32:0]             hi_sum;
	logic [31:0]             hi_red;
	logic [31:0]             hi_mod;
	logic [63:0]             gamma_res;
	logic                    out_free;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = gbcm_pkg::reg_idx_t'(paddr[5:3]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			keys[2*j]   = key_q[j][31:0];
			keys[2*j+1] = key_q[j][63:32];
		end
	end

	always_comb begin
		unique case (reg_idx)
			gbcm_pkg::REG_KEY01: prdata = key_q[0];
			gbcm_pkg::REG_KEY23: prdata = key_q[1];
			gbcm_pkg::REG_KEY45: prdata = key_q[2];
			gbcm_pkg::REG_KEY67: prdata = key_q[3];
			gbcm_pkg::REG_MODE:  prdata = {61'd0, mode_cfg_q};
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q      <= '0;
			mode_cfg_q <= gbcm_pkg::MODE_ECB_ENC;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				gbcm_pkg::REG_KEY01: key_q[0]   <= pwdata;
				gbcm_pkg::REG_KEY23: key_q[1]   <= pwdata;
				gbcm_pkg::REG_KEY45: key_q[2]   <= pwdata;
				gbcm_pkg::REG_KEY67: key_q[3]   <= pwdata;
				gbcm_pkg::REG_MODE:  mode_cfg_q <= gbcm_pkg::mode_t'(pwdata[2:0]);
				default: ;
			endcase
		end
	end

	// ---------------- input decode ----------------
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign op_in     = gbcm_pkg::op_t'(op);
	assign data_xfer = in_xfer && (op_in == gbcm_pkg::OP_DATA);
	assign mode_cur  = mode_cfg_q;

	// Clamp the count to eight and keep only the valid low bytes.
	assign cnt_sat = (byte_count > 4'd8) ? 4'd8 : byte_count;
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			mask_in[8*b +: 8] = (4'(b) < cnt_sat) ? 8'hFF : 8'h00;
		end
	end
	assign blk_in   = payload & mask_in;
	assign ecb_full = (cnt_sat == 4'd8);

	// Counter step: low half mod 2^32, high half mod 2^32-1 kept in 1..2^32-1.
	assign adv_in = (state_q == ST_RUN1) ? core_dout : cv_q;
	assign hi_sum = {1'b0, adv_in[63:32]} + {1'b0, gbcm_pkg::GAMMA_STEP_HIGH - 32'd1};
	assign hi_red = hi_sum[31:0] + {31'd0, hi_sum[32]};
	assign hi_mod = (hi_red == 32'hFFFF_FFFF) ? 32'd0 : hi_red;
	assign adv_out = {hi_mod + 32'd1, adv_in[31:0] + gbcm_pkg::GAMMA_STEP_LOW};

	// Pick the cipher run to launch on a transfer or after the counter's first encrypt.
	always_comb begin
		core_ctl.start = 1'b0;
		core_ctl.kind  = gbcm_pkg::RUN_ENC;
		core_din       = cv_q;
		if (state_q == ST_RUN1) begin
			core_ctl.start = core_done;
			core_din       = adv_out;
		end else if (data_xfer) begin
			case (mode_cur)
				gbcm_pkg::MODE_ECB_ENC: begin
					core_ctl.start = ecb_full;
					core_din       = blk_in;
				end
				gbcm_pkg::MODE_ECB_DEC: begin
					core_ctl.start = ecb_full;
					core_ctl.kind  = gbcm_pkg::RUN_DEC;
					core_din       = blk_in;
				end
				gbcm_pkg::MODE_CTR: begin
					core_ctl.start = 1'b1;
					core_din       = msg_start_q ? cv_q : adv_out;
				end
				gbcm_pkg::MODE_CFB_ENC, gbcm_pkg::MODE_CFB_DEC: begin
					core_ctl.start = 1'b1;
					core_din       = cv_q;
				end
				gbcm_pkg::MODE_MAC: begin
					core_ctl.start = 1'b1;
					core_ctl.kind  = gbcm_pkg::RUN_MAC;
					core_din       = (msg_start_q ? 64'd0 : cv_q) ^ blk_in;
				end
				default: ;
			endcase
		end
	end

	gbcm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (core_ctl),
		.din    (core_din),
		.keys   (keys),
		.sbox   (sbox_q),
		.done   (core_done),
		.dout   (core_dout)
	);

	assign gamma_res = (blk_q ^ core_dout) & mask_q;
	assign out_free  = !out_valid_q || out_ready;

	// ---------------- sequencer and state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cv_q        <= '0;
			msg_start_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// Raise valid as the held block moves out; drop it once the receiver takes it.
			if (state_q == ST_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						case (op_in)
							gbcm_pkg::OP_SYNC: begin
								cv_q        <= payload;
								msg_start_q <= 1'b1;
							end
							gbcm_pkg::OP_DATA: begin
								msg_start_q <= last;
								if (mode_cur == gbcm_pkg::MODE_CTR && !msg_start_q) begin
									cv_q <= adv_out;
								end
								if (!core_ctl.start) begin
									state_q <= ST_HOLD;
								end else if (mode_cur == gbcm_pkg::MODE_CTR && msg_start_q) begin
									state_q <= ST_RUN1;
								end else begin
									state_q <= ST_RUN2;
								end
							end
							default: ;
						endcase
					end
				end
				ST_RUN1: begin
					// Encrypted sync value becomes the counter; advance it and run again.
					if (core_done) begin
						cv_q    <= adv_out;
						state_q <= ST_RUN2;
					end
				end
				ST_RUN2: begin
					if (core_done) begin
						case (mode_q)
							gbcm_pkg::MODE_CFB_ENC: begin
								if (!last_q) cv_q <= gamma_res;
							end
							gbcm_pkg::MODE_CFB_DEC: begin
								if (!last_q) cv_q <= blk_q;
							end
							gbcm_pkg::MODE_MAC: cv_q <= core_dout;
							default: ;
						endcase
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers: block fields, substitution rows, holding and output data.
	always_ff @(posedge clk) begin
		if (in_xfer && op_in == gbcm_pkg::OP_ROW) begin
			sbox_q[row_index] <= payload;
		end
		if (data_xfer) begin
			blk_q       <= blk_in;
			mask_q      <= mask_in;
			cnt_q       <= byte_count;
			last_q      <= last;
			mode_q      <= mode_cur;
			// Blocks that skip the rounds are settled here.
			hold_data_q <= blk_in;
			hold_mac_q  <= '0;
			hold_err_q  <= (mode_cur == gbcm_pkg::MODE_ECB_ENC ||
				mode_cur == gbcm_pkg::MODE_ECB_DEC) && !ecb_full;
		end
		if (state_q == ST_RUN2 && core_done) begin
			case (mode_q)
				gbcm_pkg::MODE_ECB_ENC, gbcm_pkg::MODE_ECB_DEC: hold_data_q <= core_dout;
				gbcm_pkg::MODE_CTR, gbcm_pkg::MODE_CFB_ENC,
				gbcm_pkg::MODE_CFB_DEC: hold_data_q <= gamma_res;
				gbcm_pkg::MODE_MAC: begin
					hold_data_q <= blk_q;
					hold_mac_q  <= last_q ? core_dout[31:0] : 32'd0;
				end
				default: ;
			endcase
		end
		if (state_q == ST_HOLD && out_free) begin
			data_out_q <= hold_data_q;
			mac_out_q  <= hold_mac_q;
			vb_out_q   <= cnt_q;
			fb_out_q   <= last_q;
			err_out_q  <= hold_err_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_out     = data_out_q;
	assign mac_value    = mac_out_q;
	assign valid_bytes  = vb_out_q;
	assign final_block  = fb_out_q;
	assign length_error = err_out_q;

endmodule

### design/gbcm_round.sv
// One Feistel round: key add, eight nibble substitutions, rotate, xor.
module gbcm_round (
	input  logic [63:0]     d,
	input  logic [31:0]     k,
	input  gbcm_pkg::sbox_t sbox,
	output logic [63:0]     q
);

	logic [31:0] lo;
	logic [31:0] hi;
	logic [31:0] sum;
	logic [31:0] sub;
	logic [31:0] rot;

	assign lo  = d[31:0];
	assign hi  = d[63:32];
	assign sum = lo + k;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			sub[4*i +: 4] = sbox[i][4*sum[4*i +: 4] +: 4];
		end
	end

	assign rot = {sub[31-gbcm_pkg::ROTATE_BITS:0], sub[31:32-gbcm_pkg::ROTATE_BITS]};
	assign q   = {lo, rot ^ hi};

endmodule

### design/gbcm_core.sv
// Round sequencer: runs the shared round unit 32 or 16 times per block.
module gbcm_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gbcm_pkg::core_ctl_t    ctl,
	input  logic [63:0]            din,
	input  gbcm_pkg::key_words_t   keys,
	input  gbcm_pkg::sbox_t        sbox,
	output logic                   done,
	output logic [63:0]            dout
);

	logic [63:0]         data_q;
	logic [4:0]          rnd_q;
	logic                busy_q;
	logic                done_q;
	gbcm_pkg::run_kind_t kind_q;
	logic [2:0]          kidx;
	logic [4:0]          last_rnd;
	logic [63:0]         rnd_out;

	// Key order: encrypt 0..7 three times then 7..0; decrypt the reverse.
	always_comb begin
		unique case (kind_q)
			gbcm_pkg::RUN_ENC: kidx = (rnd_q[4:3] == 2'b11) ? ~rnd_q[2:0] : rnd_q[2:0];
			gbcm_pkg::RUN_DEC: kidx = (rnd_q[4:3] == 2'b00) ? rnd_q[2:0] : ~rnd_q[2:0];
			default:           kidx = rnd_q[2:0];
		endcase
	end

	assign last_rnd = (kind_q == gbcm_pkg::RUN_MAC) ? 5'd15 : 5'd31;

	gbcm_round u_round (
		.d    (data_q),
		.k    (keys[kidx]),
		.sbox (sbox),
		.q    (rnd_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
			kind_q <= gbcm_pkg::RUN_ENC;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
				kind_q <= ctl.kind;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 5'd1;
				if (rnd_q == last_rnd) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			data_q <= din;
		end else if (busy_q) begin
			data_q <= rnd_out;
		end
	end

	assign done = done_q;
	// The full cipher ends with a half swap; the MAC rounds do not.
	assign dout = (kind_q == gbcm_pkg::RUN_MAC) ? data_q : {data_q[31:0], data_q[63:32]};

endmodule

### tb/gost_block_cipher_modes_tb.sv
// Self-checking testbench for the GOST 28147-89 cipher engine in all of its block modes.
`timescale 1ns / 1ps

module gost_block_cipher_modes_tb;

	// Cycles without any transfer before the run is declared hung. The slowest
	// block is a first counter block (64 rounds plus handoff); the rest is slack
	// for long random receiver stalls.
	localparam int unsigned STALL_LIMIT   = 4000;
	// Quiet time before a register write and at the end of the run.
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam int unsigned REPORT_MAX    = 10;
	localparam int unsigned SEGMENT_ITEMS = 38;

	typedef struct packed {
		logic [63:0] data;
		logic [31:0] mac;
		logic [3:0]  count;
		logic        fin;
		logic        err;
	} block_result_t;

	// Tracks keys, mode, substitution rows and chaining state, and keeps the
	// cipher results still owed by the block in transfer order.
	class magma_block_tracker;
		logic [63:0]     key_pair [4];
		logic [63:0]     sbox_rows [gbcm_pkg::SBOX_ROWS];
		logic [63:0]     chain;
		gbcm_pkg::mode_t cur_mode;
		bit              fresh_msg;
		block_result_t   owed_blocks [$];
		int unsigned     mismatches;
		int unsigned     blocks_checked;

		function new();
			int i;
			for (i = 0; i < 4; i++) key_pair[i] = '0;
			for (i = 0; i < gbcm_pkg::SBOX_ROWS; i++) sbox_rows[i] = '0;
			chain          = '0;
			cur_mode       = gbcm_pkg::MODE_ECB_ENC;
			fresh_msg      = 1'b1;
			mismatches     = 0;
			blocks_checked = 0;
		endfunction

		function void set_reg(gbcm_pkg::reg_idx_t idx, logic [63:0] value);
			if (idx == gbcm_pkg::REG_MODE) begin
				cur_mode = gbcm_pkg::mode_t'(value[2:0]);
			end else begin
				key_pair[int'(idx)] = value;
			end
		endfunction

		function logic [31:0] key_word(int j);
			logic [63:0] pr;
			pr = key_pair[(j / 2) % 4];
			return (j % 2) ? pr[63:32] : pr[31:0];
		endfunction

		function logic [63:0] feistel_round(logic [63:0] d, int j);
			logic [31:0] lo, hi, s, t;
			logic [3:0]  nib;
			int          i;
			lo = d[31:0];
			hi = d[63:32];
			s  = lo + key_word(j);
			t  = '0;
			for (i = 0; i < 8; i++) begin
				nib = s[4*i +: 4];
				t[4*i +: 4] = sbox_rows[i][4*nib +: 4];
			end
			t = (t << gbcm_pkg::ROTATE_BITS) | (t >> (32 - gbcm_pkg::ROTATE_BITS));
			return {lo, t ^ hi};
		endfunction

		function logic [63:0] encrypt_block(logic [63:0] d);
			int r;
			for (r = 0; r < 24; r++) d = feistel_round(d, r % 8);
			for (r = 0; r < 8; r++) d = feistel_round(d, 7 - r);
			return {d[31:0], d[63:32]};
		endfunction

		function logic [63:0] decrypt_block(logic [63:0] d);
			int r;
			for (r = 0; r < 8; r++) d = feistel_round(d, r);
			for (r = 0; r < 24; r++) d = feistel_round(d, 7 - (r % 8));
			return {d[31:0], d[63:32]};
		endfunction

		function logic [63:0] mac_rounds(logic [63:0] d);
			int r;
			for (r = 0; r < 16; r++) d = feistel_round(d, r % 8);
			return d;
		endfunction

		function logic [63:0] step_counter(logic [63:0] c);
			logic [31:0] lo;
			logic [63:0] hi;
			lo = c[31:0] + gbcm_pkg::GAMMA_STEP_LOW;
			hi = {32'd0, c[63:32]};
			hi = (hi + {32'd0, gbcm_pkg::GAMMA_STEP_HIGH} - 64'd1) % 64'hFFFF_FFFF + 64'd1;
			return {hi[31:0], lo};
		endfunction

		// Update the state for one accepted input transfer; queue a result for a data block.
		function void note_transfer(logic [1:0] op_in, logic [63:0] word, logic [2:0] row,
				logic [3:0] cnt_in, logic lst);
			logic [3:0]    cnt;
			logic [63:0]   mask, blk;
			block_result_t res;
			case (op_in)
				gbcm_pkg::OP_SYNC: begin
					chain     = word;
					fresh_msg = 1'b1;
				end
				gbcm_pkg::OP_ROW: sbox_rows[row] = word;
				gbcm_pkg::OP_DATA: begin
					cnt  = (cnt_in > 4'd8) ? 4'd8 : cnt_in;
					mask = (cnt == 4'd8) ? '1 : ((64'd1 << (8 * cnt)) - 64'd1);
					blk  = word & mask;
					res  = '0;
					res.count = cnt_in;
					res.fin   = lst;
					case (cur_mode)
						gbcm_pkg::MODE_ECB_ENC, gbcm_pkg::MODE_ECB_DEC: begin
							if (cnt < 4'd8) begin
								res.data = blk;
								res.err  = 1'b1;
							end else begin
								res.data = (cur_mode == gbcm_pkg::MODE_ECB_ENC) ?
									encrypt_block(blk) : decrypt_block(blk);
							end
						end
						gbcm_pkg::MODE_CTR: begin
							if (fresh_msg) chain = encrypt_block(chain);
							chain    = step_counter(chain);
							res.data = (blk ^ encrypt_block(chain)) & mask;
						end
						gbcm_pkg::MODE_CFB_ENC, gbcm_pkg::MODE_CFB_DEC: begin
							res.data = (blk ^ encrypt_block(chain)) & mask;
							if (!lst) begin
								chain = (cur_mode == gbcm_pkg::MODE_CFB_ENC) ? res.data : blk;
							end
						end
						gbcm_pkg::MODE_MAC: begin
							if (fresh_msg) chain = '0;
							chain    = mac_rounds(chain ^ blk);
							res.data = blk;
							if (lst) res.mac = chain[31:0];
						end
						default: res.data = blk;
					endcase
					fresh_msg = lst;
					owed_blocks.push_back(res);
				end
				default: ;
			endcase
		endfunction

		function void check_result(block_result_t got);
			block_result_t want;
			if (owed_blocks.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("ERROR: result with nothing owed: data %h mac %h bytes %0d",
						got.data, got.mac, got.count);
				return;
			end
			want = owed_blocks.pop_front();
			blocks_checked++;
			if (got.data !== want.data || got.mac !== want.mac || got.count !== want.count ||
					got.fin !== want.fin || got.err !== want.err) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("ERROR: block %0d expected data %h mac %h bytes %0d last %b err %b",
						blocks_checked, want.data, want.mac, want.count, want.fin, want.err);
					$display("       block %0d actual   data %h mac %h bytes %0d last %b err %b",
						blocks_checked, got.data, got.mac, got.count, got.fin, got.err);
				end
			end
		endfunction

		function int unsigned owed();
			return owed_blocks.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid, in_ready;
	logic [1:0]  op;
	logic [63:0] payload;
	logic [2:0]  row_index;
	logic [3:0]  byte_count;
	logic        last;
	logic        out_valid, out_ready;
	logic [63:0] data_out;
	logic [31:0] mac_value;
	logic [3:0]  valid_bytes;
	logic        final_block;
	logic        length_error;

	magma_block_tracker tracker;
	int unsigned        tx_idle_pct;
	int unsigned        rx_idle_pct;
	int unsigned        idle_cycles;
	int unsigned        settings_used;
	int unsigned        messages_sent;
	bit                 moved;

	gost_block_cipher_modes dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.payload      (payload),
		.row_index    (row_index),
		.byte_count   (byte_count),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_out     (data_out),
		.mac_value    (mac_value),
		.valid_bytes  (valid_bytes),
		.final_block  (final_block),
		.length_error (length_error)
	);

	// 4 ns clock.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver pacing: drop out_ready on a random share of cycles.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Monitor both channels on the pre-edge values. Check the output first, so a
	// result never consumes an expectation queued at the same edge. The watchdog
	// restarts on any transfer or register write.
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (out_valid && out_ready) begin
				tracker.check_result({data_out, mac_value, valid_bytes, final_block,
					length_error});
				moved = 1'b1;
			end
			if (in_valid && in_ready) begin
				tracker.note_transfer(op, payload, row_index, byte_count, last);
				moved = 1'b1;
			end
			if (psel && penable && pwrite && pready) moved = 1'b1;
			if (moved) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: %0d cycles without a transfer, %0d results still owed",
					idle_cycles, tracker.owed());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic logic [63:0] rand_word();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8) return '0;
		if (r < 16) return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] rand_key();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10) return '0;
		if (r < 20) return '1;
		return {$urandom, $urandom};
	endfunction

	// Register write: setup cycle, then access cycle; the write lands at the
	// edge where psel, penable, pwrite and pready are all high.
	task automatic write_reg(input gbcm_pkg::reg_idx_t idx, input logic [63:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_reg(idx, value);
	endtask

	// Present one input item. Idle first at the sender's rate, then hold valid
	// and the fields until the transfer happens. Valid is left high on return so
	// a back-to-back item never lowers and raises it in the same step.
	task automatic send_item(input logic [1:0] o, input logic [63:0] word,
			input logic [2:0] row, input logic [3:0] cnt, input logic lst);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= o;
		payload    <= word;
		row_index  <= row;
		byte_count <= cnt;
		last       <= lst;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic data_block(input logic [63:0] word, input logic [3:0] cnt,
			input logic lst);
		send_item(gbcm_pkg::OP_DATA, word, 3'($urandom_range(7)), cnt, lst);
		if (lst) messages_sent++;
	endtask

	// Drop valid, wait for every owed result, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.owed() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input gbcm_pkg::mode_t m, input bit new_keys);
		int i;
		if (new_keys) begin
			for (i = 0; i < 4; i++) write_reg(gbcm_pkg::reg_idx_t'(i), rand_key());
		end
		write_reg(gbcm_pkg::REG_MODE, {61'd0, m});
		settings_used++;
	endtask

	// Mostly well-formed messages (optional sync, one to five blocks, last on the
	// final one) with random content; the rest is row reloads, unused ops and
	// messages that never get their last mark.
	task automatic run_traffic(input int unsigned n_items);
		int unsigned sent, r, nb, k;
		bit          broken;
		logic [3:0]  cnt;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(99);
			if (r < 4) begin
				send_item(gbcm_pkg::OP_NONE, rand_word(), 3'($urandom_range(7)),
					4'($urandom_range(15)), 1'($urandom_range(1)));
			end else if (r < 8) begin
				send_item(gbcm_pkg::OP_ROW, {$urandom, $urandom}, 3'($urandom_range(7)),
					4'($urandom_range(15)), 1'($urandom_range(1)));
				sent++;
			end else begin
				if ($urandom_range(1)) begin
					send_item(gbcm_pkg::OP_SYNC, rand_word(), 3'($urandom_range(7)),
						4'($urandom_range(15)), 1'($urandom_range(1)));
					sent++;
				end
				nb     = $urandom_range(5, 1);
				broken = ($urandom_range(9) == 0);
				for (k = 0; k < nb; k++) begin
					cnt = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'd8;
					data_block(rand_word(), cnt, (k == nb - 1) && !broken);
					sent++;
				end
			end
		end
	endtask

	initial begin
		int              i, ph, sg;
		gbcm_pkg::mode_t rsv;

		tracker       = new();
		tx_idle_pct   = 13;
		rx_idle_pct   = 62;
		idle_cycles   = 0;
		settings_used = 0;
		messages_sent = 0;

		// Drive every input to a known value and hold reset.
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		in_valid   <= 1'b0;
		op         <= gbcm_pkg::OP_SYNC;
		payload    <= '0;
		row_index  <= '0;
		byte_count <= '0;
		last       <= 1'b0;
		out_ready  <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// Directed part. Keys at both extremes plus random ones, ECB encrypt.
		write_reg(gbcm_pkg::REG_KEY01, '1);
		write_reg(gbcm_pkg::REG_KEY23, '0);
		write_reg(gbcm_pkg::REG_KEY45, {$urandom, $urandom});
		write_reg(gbcm_pkg::REG_KEY67, {$urandom, $urandom});
		write_reg(gbcm_pkg::REG_MODE, {61'd0, gbcm_pkg::MODE_ECB_ENC});
		settings_used++;

		// Load every substitution row before any cipher work reads one.
		for (i = 0; i < gbcm_pkg::SBOX_ROWS; i++) begin
			send_item(gbcm_pkg::OP_ROW, (i == 0) ? '1 : ((i == 7) ? '0 : {$urandom, $urandom}),
				3'(i), 4'($urandom_range(15)), 1'($urandom_range(1)));
		end
		// Unused op: ignored, no result.
		send_item(gbcm_pkg::OP_NONE, {$urandom, $urandom}, 3'd5, 4'd8, 1'b1);
		data_block('0, 4'd8, 1'b0);
		data_block('1, 4'd8, 1'b1);
		// Short block in ECB: passed through masked, flagged.
		data_block('1, 4'd3, 1'b1);
		// No valid bytes at all.
		data_block({$urandom, $urandom}, 4'd0, 1'b1);
		// Count above eight behaves as a full block but is echoed as given.
		data_block({$urandom, $urandom}, 4'd15, 1'b1);
		drain();

		apply_setting(gbcm_pkg::MODE_ECB_DEC, 1'b0);
		data_block({$urandom, $urandom}, 4'd8, 1'b1);
		data_block('1, 4'd7, 1'b1);
		drain();

		// Counter gamma: the first block encrypts the sync value before stepping.
		apply_setting(gbcm_pkg::MODE_CTR, 1'b0);
		send_item(gbcm_pkg::OP_SYNC, '1, 3'd0, 4'd8, 1'b0);
		data_block({$urandom, $urandom}, 4'd8, 1'b0);
		data_block({$urandom, $urandom}, 4'd5, 1'b1);
		drain();

		// Feedback modes: the last block leaves the chaining value alone.
		apply_setting(gbcm_pkg::MODE_CFB_ENC, 1'b0);
		send_item(gbcm_pkg::OP_SYNC, {$urandom, $urandom}, 3'd0, 4'd8, 1'b0);
		data_block({$urandom, $urandom}, 4'd8, 1'b0);
		data_block({$urandom, $urandom}, 4'd8, 1'b1);
		drain();

		apply_setting(gbcm_pkg::MODE_CFB_DEC, 1'b0);
		send_item(gbcm_pkg::OP_SYNC, '0, 3'd7, 4'd8, 1'b1);
		data_block({$urandom, $urandom}, 4'd8, 1'b0);
		data_block({$urandom, $urandom}, 4'd2, 1'b1);
		drain();

		// MAC: value appears only with the last block.
		apply_setting(gbcm_pkg::MODE_MAC, 1'b0);
		data_block({$urandom, $urandom}, 4'd8, 1'b0);
		data_block({$urandom, $urandom}, 4'd6, 1'b1);
		drain();

		// Undefined modes pass the masked block through.
		apply_setting(gbcm_pkg::MODE_RSVD6, 1'b0);
		data_block({$urandom, $urandom}, 4'd4, 1'b1);
		drain();
		apply_setting(gbcm_pkg::MODE_RSVD7, 1'b1);
		data_block({$urandom, $urandom}, 4'd8, 1'b0);
		drain();

		// Random part: three pacing profiles, each walking through all six modes
		// with fresh keys, then a short stretch in an undefined mode.
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 13;
					rx_idle_pct = 62;
				end
				1: begin
					tx_idle_pct = 62;
					rx_idle_pct = 13;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (sg = 0; sg < 6; sg++) begin
				apply_setting(gbcm_pkg::mode_t'(sg), 1'b1);
				run_traffic(SEGMENT_ITEMS);
				drain();
			end
			rsv = $urandom_range(1) ? gbcm_pkg::MODE_RSVD6 : gbcm_pkg::MODE_RSVD7;
			apply_setting(rsv, 1'b0);
			run_traffic(6);
			drain();
		end

		$display("Covered %0d checked blocks in %0d messages over %0d register settings,",
			tracker.blocks_checked, messages_sent, settings_used);
		$display("all six modes plus undefined ones, under three handshake pacing profiles.");
		if (tracker.mismatches == 0 && tracker.owed() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results never arrived", tracker.mismatches,
				tracker.owed());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### files.f
design/gbcm_pkg.sv
design/gbcm_round.sv
design/gbcm_core.sv
design/gost_block_cipher_modes.sv
tb/gost_block_cipher_modes_tb.sv
